@@ sv/nms_pkg.sv @@
// Shared constants and controller/datapath interface types for box NMS.
`default_nettype none
package nms_pkg;
  localparam int MAX_DETS  = 64;
  localparam int IDX_W     = 6;
  localparam int CNT_W     = 7;
  localparam int COORD_W   = 16;
  localparam int BOX_W     = 4 * COORD_W;
  localparam int SCORE_W   = 16;
  localparam int LIMIT_W   = 16;
  localparam int IN_DATA_W = 80;
  localparam int OUT_DATA_W = 8;

  typedef struct packed {
    logic             load_we;
    logic             drop;
    logic [IDX_W-1:0] wr_addr;
    logic [IDX_W-1:0] sc_addr;
    logic             cap_si;
    logic             rank_clr;
    logic             rank_step;
    logic             j_lt_i;
    logic             rank_we;
    logic [IDX_W-1:0] rank_wdata;
    logic [IDX_W-1:0] rk_addr;
    logic             cap_a;
    logic             cap_boxa;
    logic             emit;
    logic             cap_b;
    logic             mul;
    logic             sum;
    logic             cmp;
    logic             flush;
  } nms_cmd_t;

  typedef struct packed {
    logic out_free;
    logic a_sup;
  } nms_stat_t;
endpackage
`default_nettype wire

@@ sv/box_non_max_suppression.sv @@
// Top level of the greedy IoU box non-maximum suppression block.
//
// Channel  Dir  Handshake               Payload
// s_axis   in   tvalid/tready           tdata edges+score, tlast final_item
// m_axis   out  tvalid/tready           tdata kept_index, tlast end, tuser overflow
// cfg      in   cfg_valid/cfg_ready     iou_limit
//
// Loading takes one item per cycle. After the final item the rank sort reads each
// item's score, then every score, from the score RAM. Suppression reads each kept
// box, then reads, multiplies, sums and compares each later box. Reset clears
// control and flags; the stores need no clearing. Output stalls hold the
// suppression pass at the next kept index; loading resumes after the set ends.
`default_nettype none
module box_non_max_suppression (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          s_axis_tvalid_i,
  output      logic                          s_axis_tready_o,
  // left_edge, top_edge, right_edge, bottom_edge, confidence
  input  wire logic [nms_pkg::IN_DATA_W-1:0] s_axis_tdata_i,
  input  wire logic                          s_axis_tlast_i,
  output      logic                          m_axis_tvalid_o,
  input  wire logic                          m_axis_tready_i,
  // kept_index, zero fill
  output      logic [nms_pkg::OUT_DATA_W-1:0] m_axis_tdata_o,
  output      logic                          m_axis_tlast_o,
  // overflow
  output      logic                          m_axis_tuser_o,
  input  wire logic                          cfg_valid_i,
  output      logic                          cfg_ready_o,
  input  wire logic [nms_pkg::LIMIT_W-1:0]   cfg_data_i
);
  import nms_pkg::*;

  nms_cmd_t         cmd;
  nms_stat_t        stat;
  logic [IDX_W-1:0] idx;

  nms_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i(s_axis_tvalid_i), .in_last_i(s_axis_tlast_i),
    .in_ready_o(s_axis_tready_o), .stat_i(stat), .cmd_o(cmd)
  );

  nms_datapath u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .stat_o(stat),
    .in_data_i(s_axis_tdata_i),
    .cfg_we_i(cfg_valid_i), .cfg_data_i(cfg_data_i),
    .out_valid_o(m_axis_tvalid_o), .out_ready_i(m_axis_tready_i),
    .out_idx_o(idx), .out_last_o(m_axis_tlast_o), .out_ovf_o(m_axis_tuser_o)
  );

  assign m_axis_tdata_o = {{(OUT_DATA_W-IDX_W){1'b0}}, idx};
  assign cfg_ready_o    = 1'b1;
endmodule
`default_nettype wire

@@ sv/nms_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module nms_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output      logic [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule
`default_nettype wire

@@ sv/nms_datapath.sv @@
// Datapath: detection stores, rank counter, IoU arithmetic, flags and output register.
`default_nettype none
module nms_datapath (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire nms_pkg::nms_cmd_t             cmd_i,
  output      nms_pkg::nms_stat_t            stat_o,
  input  wire logic [nms_pkg::IN_DATA_W-1:0] in_data_i,
  input  wire logic                          cfg_we_i,
  input  wire logic [nms_pkg::LIMIT_W-1:0]   cfg_data_i,
  output      logic                          out_valid_o,
  input  wire logic                          out_ready_i,
  output      logic [nms_pkg::IDX_W-1:0]     out_idx_o,
  output      logic                          out_last_o,
  output      logic                          out_ovf_o
);
  import nms_pkg::*;

  logic [LIMIT_W-1:0]  limit_q;
  logic [SCORE_W-1:0]  sc_rdata, si_q;
  logic [IDX_W-1:0]    rank_q, rk_rdata, a_q, b_q, pend_q;
  logic [BOX_W-1:0]    box_rdata, box_a_q;
  logic [MAX_DETS-1:0] sup_q;
  logic                ovf_q, pend_v_q, out_v_q;
  logic signed [33:0]  area_a_q, area_b_q;
  logic [31:0]         inter_q;
  logic signed [35:0]  uni_q;

  nms_ram #(.WIDTH(BOX_W), .DEPTH(MAX_DETS)) u_box_ram (
    .clk_i, .we_i(cmd_i.load_we), .waddr_i(cmd_i.wr_addr),
    .wdata_i(in_data_i[BOX_W-1:0]), .raddr_i(rk_rdata), .rdata_o(box_rdata)
  );
  nms_ram #(.WIDTH(SCORE_W), .DEPTH(MAX_DETS)) u_score_ram (
    .clk_i, .we_i(cmd_i.load_we), .waddr_i(cmd_i.wr_addr),
    .wdata_i(in_data_i[BOX_W+SCORE_W-1:BOX_W]), .raddr_i(cmd_i.sc_addr), .rdata_o(sc_rdata)
  );
  nms_ram #(.WIDTH(IDX_W), .DEPTH(MAX_DETS)) u_rank_ram (
    .clk_i, .we_i(cmd_i.rank_we), .waddr_i(rank_q),
    .wdata_i(cmd_i.rank_wdata), .raddr_i(cmd_i.rk_addr), .rdata_o(rk_rdata)
  );

  // box geometry
  logic [COORD_W-1:0] ax0, ay0, ax1, ay1, bx0, by0, bx1, by1, lox, loy, hix, hiy;
  logic signed [COORD_W:0] w_s, h_s, bw_s, bh_s, aw_s, ah_s;
  logic [COORD_W-1:0] w_c, h_c;
  logic [50:0] lhs, rhs;
  logic        hit, out_free;

  always_comb begin
    ax0 = box_a_q[15:0];  ay0 = box_a_q[31:16];
    ax1 = box_a_q[47:32]; ay1 = box_a_q[63:48];
    bx0 = box_rdata[15:0];  by0 = box_rdata[31:16];
    bx1 = box_rdata[47:32]; by1 = box_rdata[63:48];
    lox = (ax0 > bx0) ? ax0 : bx0;
    loy = (ay0 > by0) ? ay0 : by0;
    hix = (ax1 < bx1) ? ax1 : bx1;
    hiy = (ay1 < by1) ? ay1 : by1;
    w_s = $signed({1'b0, hix}) - $signed({1'b0, lox});
    h_s = $signed({1'b0, hiy}) - $signed({1'b0, loy});
    w_c = w_s[COORD_W] ? '0 : w_s[COORD_W-1:0];
    h_c = h_s[COORD_W] ? '0 : h_s[COORD_W-1:0];
    bw_s = $signed({1'b0, bx1}) - $signed({1'b0, bx0});
    bh_s = $signed({1'b0, by1}) - $signed({1'b0, by0});
    aw_s = $signed({1'b0, ax1}) - $signed({1'b0, ax0});
    ah_s = $signed({1'b0, ay1}) - $signed({1'b0, ay0});
    lhs = {3'b000, inter_q, 16'h0000};
    rhs = limit_q * uni_q[34:0];
    hit = !uni_q[35] && (uni_q != '0) && (lhs > rhs);
    out_free = !out_v_q || out_ready_i;
  end

  assign stat_o.out_free = out_free;
  assign stat_o.a_sup    = sup_q[a_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q  <= LIMIT_W'(32768);
      sup_q    <= '0;
      ovf_q    <= 1'b0;
      pend_v_q <= 1'b0;
      out_v_q  <= 1'b0;
    end else begin
      if (cfg_we_i) limit_q <= cfg_data_i;
      if (cmd_i.drop) ovf_q <= 1'b1;
      if (cmd_i.cmp && hit) sup_q[b_q] <= 1'b1;
      out_v_q <= ((cmd_i.emit || cmd_i.flush) && pend_v_q) || (out_v_q && !out_ready_i);
      if (cmd_i.emit) begin
        pend_v_q <= 1'b1;
      end
      if (cmd_i.flush) begin
        pend_v_q <= 1'b0;
        sup_q    <= '0;
        ovf_q    <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.cap_si) si_q <= sc_rdata;
    if (cmd_i.rank_clr) begin
      rank_q <= '0;
    end else if (cmd_i.rank_step) begin
      if ((sc_rdata > si_q) || ((sc_rdata == si_q) && cmd_i.j_lt_i)) rank_q <= rank_q + 1'b1;
    end
    if (cmd_i.cap_a) a_q <= rk_rdata;
    if (cmd_i.cap_b) b_q <= rk_rdata;
    if (cmd_i.cap_boxa) box_a_q <= box_rdata;
    if (cmd_i.emit) begin
      area_a_q <= aw_s * ah_s;
      pend_q   <= a_q;
      if (pend_v_q) begin
        out_idx_o  <= pend_q;
        out_last_o <= 1'b0;
        out_ovf_o  <= ovf_q;
      end
    end
    if (cmd_i.flush && pend_v_q) begin
      out_idx_o  <= pend_q;
      out_last_o <= 1'b1;
      out_ovf_o  <= ovf_q;
    end
    if (cmd_i.mul) begin
      inter_q  <= w_c * h_c;
      area_b_q <= bw_s * bh_s;
    end
    if (cmd_i.sum) begin
      uni_q <= 36'(area_a_q) + 36'(area_b_q) - $signed({4'b0000, inter_q});
    end
  end

  assign out_valid_o = out_v_q;
endmodule
`default_nettype wire

@@ sv/nms_ctrl.sv @@
// Controller: load, rank-sort and suppression sequencing.
`default_nettype none
module nms_ctrl (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  input  wire logic               in_last_i,
  output      logic               in_ready_o,
  input  wire nms_pkg::nms_stat_t stat_i,
  output      nms_pkg::nms_cmd_t  cmd_o
);
  import nms_pkg::*;

  localparam logic [3:0] S_LOAD   = 4'd0;
  localparam logic [3:0] S_SI_RD  = 4'd1;
  localparam logic [3:0] S_SI_CAP = 4'd2;
  localparam logic [3:0] S_SJ_RD  = 4'd3;
  localparam logic [3:0] S_SJ_CMP = 4'd4;
  localparam logic [3:0] S_RK_WR  = 4'd5;
  localparam logic [3:0] S_A_RD   = 4'd6;
  localparam logic [3:0] S_A_FLG  = 4'd7;
  localparam logic [3:0] S_A_CAP  = 4'd8;
  localparam logic [3:0] S_A_EMIT = 4'd9;
  localparam logic [3:0] S_B_RD   = 4'd10;
  localparam logic [3:0] S_B_BOX  = 4'd11;
  localparam logic [3:0] S_B_MUL  = 4'd12;
  localparam logic [3:0] S_B_SUM  = 4'd13;
  localparam logic [3:0] S_B_CMP  = 4'd14;
  localparam logic [3:0] S_FLUSH  = 4'd15;

  logic [3:0]       state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d, i_q, i_d, j_q, j_d;
  logic             room, i_end;

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    i_d     = i_q;
    j_d     = j_q;
    cmd_o   = '0;
    cmd_o.wr_addr    = cnt_q[IDX_W-1:0];
    cmd_o.sc_addr    = (state_q == S_SI_RD) ? i_q[IDX_W-1:0] : j_q[IDX_W-1:0];
    cmd_o.rk_addr    = (state_q == S_A_RD) ? i_q[IDX_W-1:0] : j_q[IDX_W-1:0];
    cmd_o.rank_wdata = i_q[IDX_W-1:0];
    cmd_o.j_lt_i     = j_q < i_q;
    room       = cnt_q < CNT_W'(MAX_DETS);
    i_end      = (i_q + 1'b1) == cnt_q;
    in_ready_o = (state_q == S_LOAD);
    case (state_q)
      S_LOAD: begin
        if (in_valid_i) begin
          if (room) begin
            cmd_o.load_we = 1'b1;
            cnt_d = cnt_q + 1'b1;
          end else begin
            cmd_o.drop = 1'b1;
          end
          if (in_last_i) begin
            i_d = '0;
            state_d = S_SI_RD;
          end
        end
      end
      S_SI_RD: state_d = S_SI_CAP;
      S_SI_CAP: begin
        cmd_o.cap_si = 1'b1;
        cmd_o.rank_clr = 1'b1;
        j_d = '0;
        state_d = S_SJ_RD;
      end
      S_SJ_RD: state_d = S_SJ_CMP;
      S_SJ_CMP: begin
        cmd_o.rank_step = 1'b1;
        j_d = j_q + 1'b1;
        state_d = ((j_q + 1'b1) == cnt_q) ? S_RK_WR : S_SJ_RD;
      end
      S_RK_WR: begin
        cmd_o.rank_we = 1'b1;
        i_d = i_q + 1'b1;
        state_d = i_end ? S_A_RD : S_SI_RD;
        if (i_end) i_d = '0;
      end
      S_A_RD: state_d = S_A_FLG;
      S_A_FLG: begin
        cmd_o.cap_a = 1'b1;
        state_d = S_A_CAP;
      end
      S_A_CAP: begin
        cmd_o.cap_boxa = 1'b1;
        if (stat_i.a_sup) begin
          i_d = i_q + 1'b1;
          state_d = i_end ? S_FLUSH : S_A_RD;
        end else begin
          state_d = S_A_EMIT;
        end
      end
      S_A_EMIT: begin
        if (stat_i.out_free) begin
          cmd_o.emit = 1'b1;
          j_d = i_q + 1'b1;
          if (i_end) begin
            state_d = S_FLUSH;
          end else begin
            state_d = S_B_RD;
          end
        end
      end
      S_B_RD: state_d = S_B_BOX;
      S_B_BOX: begin
        cmd_o.cap_b = 1'b1;
        state_d = S_B_MUL;
      end
      S_B_MUL: begin
        cmd_o.mul = 1'b1;
        state_d = S_B_SUM;
      end
      S_B_SUM: begin
        cmd_o.sum = 1'b1;
        state_d = S_B_CMP;
      end
      S_B_CMP: begin
        cmd_o.cmp = 1'b1;
        j_d = j_q + 1'b1;
        if ((j_q + 1'b1) == cnt_q) begin
          i_d = i_q + 1'b1;
          state_d = i_end ? S_FLUSH : S_A_RD;
        end else begin
          state_d = S_B_RD;
        end
      end
      S_FLUSH: begin
        if (stat_i.out_free) begin
          cmd_o.flush = 1'b1;
          cnt_d = '0;
          state_d = S_LOAD;
        end
      end
      default: state_d = S_LOAD;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_LOAD;
      cnt_q   <= '0;
      i_q     <= '0;
      j_q     <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      i_q     <= i_d;
      j_q     <= j_d;
    end
  end
endmodule
`default_nettype wire

@@ sv/nms_checker.sv @@
// Port-level checks for the box NMS top level, bound to it.
`default_nettype none
module nms_checker (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       s_axis_tvalid_i,
  input wire logic       s_axis_tready_o,
  input wire logic       s_axis_tlast_i,
  input wire logic       m_axis_tvalid_o,
  input wire logic       m_axis_tready_i,
  input wire logic [7:0] m_axis_tdata_o,
  input wire logic       m_axis_tlast_o,
  input wire logic       m_axis_tuser_o
);
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=>
      m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tlast_o)
      && $stable(m_axis_tuser_o))
    else $error("output item changed while stalled");

  a_busy_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o && s_axis_tlast_i |=> !s_axis_tready_o)
    else $error("input taken right after final item");

  a_no_out_after_reset: assert property (@(posedge clk_i)
    $rose(rst_ni) |-> !m_axis_tvalid_o)
    else $error("output valid straight out of reset");
endmodule

bind box_non_max_suppression nms_checker u_nms_checker (
  .clk_i, .rst_ni, .s_axis_tvalid_i, .s_axis_tready_o, .s_axis_tlast_i,
  .m_axis_tvalid_o, .m_axis_tready_i, .m_axis_tdata_o, .m_axis_tlast_o, .m_axis_tuser_o
);
`default_nettype wire
